@@ hw/rtl/rng3d_pkg.sv @@
// Shared types and codes for the radial neighbourhood gather block.
`default_nettype none
package rng3d_pkg;

	// Input action codes
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	// Edge handling codes; any other code behaves as blocking
	localparam logic [1:0] BND_BLOCK    = 2'd0;
	localparam logic [1:0] BND_PERIODIC = 2'd1;
	localparam logic [1:0] BND_REFLECT  = 2'd2;

	// Configuration register indexes
	localparam logic [2:0] REG_BOUNDARY_MODE = 3'd0;
	localparam logic [2:0] REG_RADIUS        = 3'd1;
	localparam logic [2:0] REG_SIZE_X        = 3'd2;
	localparam logic [2:0] REG_SIZE_Y        = 3'd3;
	localparam logic [2:0] REG_SIZE_Z        = 3'd4;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH
	} state_t;

endpackage
`default_nettype wire

@@ hw/rtl/rng3d_ram.sv @@
// Generic single-port synchronous RAM with registered read data.
`default_nettype none
module rng3d_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Read data holds until the next read
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/radial_neighborhood_gather_3d.sv @@
// Top level of the radial neighbourhood gather over a 3D label grid.
//
// Input channel (in_valid / in_stall): one transfer carries an action and a cell
// position. A write stores cell_value in the grid and gives no result; writes
// can follow back to back. A query walks every offset of the (2r+1)^3 cube
// around the position, one offset per cycle unless the scan pauses for a stalled
// output, and reads the grid only for kept offsets. The grid has a single memory port.
// Each kept neighbour with a nonzero label leaves as one transfer on the output
// channel (out_valid / out_stall); the final one carries last. A query that
// finds nothing gives one transfer with found low and last high.
// Each label is held back until it is known whether another follows: it moves
// to the output register on the edge that stores the next nonzero label, or,
// as the final one, after the scan ends, the read stage drains and the output is free.
// When a label would have to push into a stalled output register, the scan
// pauses and resumes without loss; in_stall stays high until the query has finished.
// Configuration (cfg_valid / cfg_ready) is always ready; write it only while
// the block is idle.
// After reset the grid is cleared by a pass of one entry per cycle over
// 2^(3*ceil(log2(GRID_DIM))) entries (32768 entries at GRID_DIM 32); no item is
// taken meanwhile, configuration writes are.
`default_nettype none
module radial_neighborhood_gather_3d #(
	parameter int GRID_DIM   = 32,
	parameter int MAX_RADIUS = 2,
	parameter int CELL_BITS  = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [5:0]  cfg_data,

	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        action,
	input  wire logic [4:0]  pos_x,
	input  wire logic [4:0]  pos_y,
	input  wire logic [4:0]  pos_z,
	input  wire logic [15:0] cell_value,

	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [15:0]      neighbor_value,
	output logic             found,
	output logic             last
);

	import rng3d_pkg::*;

	// Coordinate width, grid address width and working widths
	localparam int CW = $clog2(GRID_DIM);
	localparam int AW = 3 * CW;
	localparam int PW = (CW > 5) ? CW : 5;
	localparam int SW = PW + 3;
	localparam int OW = $clog2(MAX_RADIUS + 1) + 1;
	localparam int DW = 2 * OW + 2;
	localparam int LW = (CELL_BITS > 16) ? CELL_BITS : 16;

	// Configuration registers
	logic [1:0] mode_q;
	logic [1:0] radius_q;
	logic [5:0] size_x_q;
	logic [5:0] size_y_q;
	logic [5:0] size_z_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= BND_BLOCK;
			radius_q <= 2'd1;
			size_x_q <= 6'd32;
			size_y_q <= 6'd32;
			size_z_q <= 6'd32;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_BOUNDARY_MODE: mode_q   <= cfg_data[1:0];
				REG_RADIUS:        radius_q <= cfg_data[1:0];
				REG_SIZE_X:        size_x_q <= cfg_data;
				REG_SIZE_Y:        size_y_q <= cfg_data;
				REG_SIZE_Z:        size_z_q <= cfg_data;
				default:           ;
			endcase
		end
	end

	// Map one coordinate onto [0, m); the top bit of the result says it is kept
	function automatic logic [CW:0] map_axis(
		input logic signed [SW-1:0] c_in,
		input logic signed [SW-1:0] m,
		input logic [1:0]           mode
	);
		logic signed [SW-1:0] c;
		logic                 ok;
		c = c_in;
		if (mode == BND_PERIODIC) begin
			if (c[SW-1]) begin
				c = c + m;
			end else if (c >= m) begin
				c = c - m;
			end
		end else if (mode == BND_REFLECT) begin
			if (c[SW-1]) begin
				c = ~c;
			end else if (c >= m) begin
				c = (m <<< 1) - c - SW'(1);
			end
		end
		ok = !c[SW-1] && (c < m);
		return {ok, c[CW-1:0]};
	endfunction

	// Effective radius and grid extents, saturated
	logic signed [OW-1:0] r_eff;
	logic signed [DW-1:0] rr;
	logic signed [SW-1:0] m_x;
	logic signed [SW-1:0] m_y;
	logic signed [SW-1:0] m_z;
	localparam logic signed [SW-1:0] GRID_S = SW'(GRID_DIM);

	assign r_eff = (radius_q > 2'(MAX_RADIUS)) ? OW'(MAX_RADIUS) : OW'(radius_q);
	assign rr    = DW'(r_eff) * DW'(r_eff);
	assign m_x   = ($signed(SW'(size_x_q)) > GRID_S) ? GRID_S : $signed(SW'(size_x_q));
	assign m_y   = ($signed(SW'(size_y_q)) > GRID_S) ? GRID_S : $signed(SW'(size_y_q));
	assign m_z   = ($signed(SW'(size_z_q)) > GRID_S) ? GRID_S : $signed(SW'(size_z_q));

	// Scan position and latched query centre
	logic signed [OW-1:0] dx_q, dy_q, dz_q;
	logic [4:0]           px_q, py_q, pz_q;

	logic signed [SW-1:0] cx_raw, cy_raw, cz_raw;
	logic [CW:0]          map_x, map_y, map_z;
	logic signed [DW-1:0] dist_sq;
	logic                 keep;
	logic                 last_off;
	logic [AW-1:0]        scan_addr;

	assign cx_raw = $signed(SW'(px_q)) + SW'(dx_q);
	assign cy_raw = $signed(SW'(py_q)) + SW'(dy_q);
	assign cz_raw = $signed(SW'(pz_q)) + SW'(dz_q);
	assign map_x  = map_axis(cx_raw, m_x, mode_q);
	assign map_y  = map_axis(cy_raw, m_y, mode_q);
	assign map_z  = map_axis(cz_raw, m_z, mode_q);
	assign dist_sq = DW'(dx_q) * DW'(dx_q) + DW'(dy_q) * DW'(dy_q) + DW'(dz_q) * DW'(dz_q);
	assign keep   = map_x[CW] && map_y[CW] && map_z[CW] && (dist_sq <= rr);
	assign scan_addr = {map_x[CW-1:0], map_y[CW-1:0], map_z[CW-1:0]};
	assign last_off  = (dx_q == r_eff) && (dy_q == r_eff) && (dz_q == r_eff);

	// Write address and range check
	logic signed [SW-1:0] wx, wy, wz;
	logic                 wr_in_grid;
	logic [AW-1:0]        wr_addr;
	logic [LW-1:0]        wr_wide;

	assign wx = $signed(SW'(pos_x));
	assign wy = $signed(SW'(pos_y));
	assign wz = $signed(SW'(pos_z));
	assign wr_in_grid = (wx < GRID_S) && (wy < GRID_S) && (wz < GRID_S);
	assign wr_addr = {wx[CW-1:0], wy[CW-1:0], wz[CW-1:0]};
	assign wr_wide = LW'(cell_value);

	// Grid memory
	logic                 ram_en;
	logic                 ram_we;
	logic [AW-1:0]        ram_addr;
	logic [CELL_BITS-1:0] ram_wdata;
	logic [CELL_BITS-1:0] ram_rdata;
	logic [LW-1:0]        rd_wide;

	rng3d_ram #(
		.WIDTH (CELL_BITS),
		.DEPTH (2 ** AW)
	) u_grid (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign rd_wide = LW'(ram_rdata);

	// Read stage, held-back label and output register
	logic        valid_s1;
	logic        pend_valid_q;
	logic [15:0] pend_data_q;
	logic        out_valid_q;
	logic [15:0] out_data_q;
	logic        out_found_q;
	logic        out_last_q;

	logic out_free;
	logic s1_nz;
	logic s1_ok;

	assign out_free = !out_valid_q || !out_stall;
	assign s1_nz    = valid_s1 && (ram_rdata != '0);
	// The read stage can move on unless a label must push the held one out
	// into a stalled output register
	assign s1_ok    = !s1_nz || !pend_valid_q || out_free;

	// Sequencer
	state_t        state_q, state_d;
	logic [AW-1:0] clr_addr_q;
	logic          start;
	logic          issue;
	logic          fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ram_en    = 1'b0;
		ram_we    = 1'b0;
		ram_addr  = scan_addr;
		ram_wdata = wr_wide[CELL_BITS-1:0];
		start     = 1'b0;
		issue     = 1'b0;
		fin       = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				ram_en    = 1'b1;
				ram_we    = 1'b1;
				ram_addr  = clr_addr_q;
				ram_wdata = '0;
				if (clr_addr_q == '1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					if (action == ACT_QUERY) begin
						start   = 1'b1;
						state_d = ST_SCAN;
					end else begin
						ram_en   = wr_in_grid;
						ram_we   = 1'b1;
						ram_addr = wr_addr;
					end
				end
			end
			ST_SCAN: begin
				if (s1_ok) begin
					issue  = 1'b1;
					ram_en = keep;
					if (last_off) begin
						state_d = ST_FLUSH;
					end
				end
			end
			ST_FLUSH: begin
				if (!valid_s1 && out_free) begin
					fin     = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q   <= '0;
			valid_s1     <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end

			if (issue) begin
				valid_s1 <= keep;
			end else if (s1_ok) begin
				valid_s1 <= 1'b0;
			end

			if (s1_nz && s1_ok) begin
				pend_valid_q <= 1'b1;
			end else if (fin) begin
				pend_valid_q <= 1'b0;
			end

			if ((s1_nz && s1_ok && pend_valid_q) || fin) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (start) begin
			px_q <= pos_x;
			py_q <= pos_y;
			pz_q <= pos_z;
			dx_q <= -r_eff;
			dy_q <= -r_eff;
			dz_q <= -r_eff;
		end else if (issue) begin
			// Advance z innermost, x outermost
			if (dz_q == r_eff) begin
				dz_q <= -r_eff;
				if (dy_q == r_eff) begin
					dy_q <= -r_eff;
					dx_q <= dx_q + OW'(1);
				end else begin
					dy_q <= dy_q + OW'(1);
				end
			end else begin
				dz_q <= dz_q + OW'(1);
			end
		end

		if (s1_nz && s1_ok) begin
			pend_data_q <= rd_wide[15:0];
		end

		if (s1_nz && s1_ok && pend_valid_q) begin
			out_data_q  <= pend_data_q;
			out_found_q <= 1'b1;
			out_last_q  <= 1'b0;
		end else if (fin) begin
			out_data_q  <= pend_valid_q ? pend_data_q : 16'd0;
			out_found_q <= pend_valid_q;
			out_last_q  <= 1'b1;
		end
	end

	assign out_valid      = out_valid_q;
	assign neighbor_value = out_data_q;
	assign found          = out_found_q;
	assign last           = out_last_q;

endmodule
`default_nettype wire
